/* hdl/scfr_pkg.sv */
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TRUST_W    = 6;
    localparam int unsigned SLOT_CNT   = 5;
    localparam int unsigned SLOT_IW    = $clog2(SLOT_CNT + 1);
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned EVT_DEPTH  = 2;
    localparam int unsigned EVT_PTR_W  = $clog2(EVT_DEPTH);
    localparam int unsigned EVT_CNT_W  = $clog2(EVT_DEPTH + 1);

    localparam logic [BYTE_W-1:0] HEAD1_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] HEAD2_BYTE = 8'hFC;
    localparam logic [BYTE_W-1:0] TASK_BAD   = 8'hFF;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_TASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRUST_LIMIT = 2'd2;

    localparam logic [BYTE_W-1:0]  RST_TRACK_TASK  = 8'd1;
    localparam logic [BYTE_W-1:0]  RST_LEN_LIMIT   = 8'd50;
    localparam logic [TRUST_W-1:0] RST_TRUST_LIMIT = 6'd20;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef t_byte t_slots [SLOT_CNT];

    // end-of-frame event passed from parser to field update
    typedef struct packed {
        logic                       sum_ok;
        t_byte                      task_code;
        logic [SLOT_CNT*BYTE_W-1:0] slots;
    } t_frame_evt;

endpackage

/* hdl/sum_checked_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_core
// Checksummed serial frame receiver with tracking field update.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Frames are FF FC, task, length, payload
// and an 8-bit additive checksum; a result is given only for a checksum byte,
// via event queue and held register, and shows the held fields after update.
// The parser only stalls when its two-entry event queue is full, that is when
// the result port has been blocked for two further frame ends. Configuration
// registers: 0 tracking task code, 1 length limit, 2 trust limit.
module sum_checked_frame_receiver_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [scfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  scfr_pkg::t_byte      i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  scfr_pkg::t_byte      i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_frame_ok,
    output scfr_pkg::t_byte      o_task_code,
    output scfr_pkg::t_byte      o_line_x,
    output scfr_pkg::t_byte      o_line_rho,
    output scfr_pkg::t_byte      o_cross_mark,
    output scfr_pkg::t_byte      o_detect_flag,
    output scfr_pkg::t_byte      o_frame_rate,
    output scfr_pkg::t_byte      o_ctrl_enable,
    output logic [scfr_pkg::TRUST_W-1:0] o_trust_count,
    output logic                 o_trusted
);
    import scfr_pkg::*;

    t_byte              r_track_task, r_len_limit;
    logic [TRUST_W-1:0] r_trust_limit;
    logic               accept, push, pop, full, nonempty;
    t_frame_evt         evt_in, evt_out;

    assign o_rx_ready = !full;
    assign accept     = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_task  <= RST_TRACK_TASK;
            r_len_limit   <= RST_LEN_LIMIT;
            r_trust_limit <= RST_TRUST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRACK_TASK:  r_track_task  <= i_cfg_data;
                CFG_LEN_LIMIT:   r_len_limit   <= i_cfg_data;
                CFG_TRUST_LIMIT: r_trust_limit <= i_cfg_data[TRUST_W-1:0];
                default: begin
                    // unmapped index: ignore
                end
            endcase
        end
    end

    scfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_len_limit (r_len_limit),
        .o_evt_push  (push),
        .o_evt       (evt_in)
    );

    scfr_evt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_evt      (evt_in),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_evt      (evt_out)
    );

    scfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt_valid   (nonempty),
        .i_evt         (evt_out),
        .o_evt_pop     (pop),
        .i_track_task  (r_track_task),
        .i_trust_limit (r_trust_limit),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_frame_ok    (o_frame_ok),
        .o_task_code   (o_task_code),
        .o_line_x      (o_line_x),
        .o_line_rho    (o_line_rho),
        .o_cross_mark  (o_cross_mark),
        .o_detect_flag (o_detect_flag),
        .o_frame_rate  (o_frame_rate),
        .o_ctrl_enable (o_ctrl_enable),
        .o_trust_count (o_trust_count),
        .o_trusted     (o_trusted)
    );

endmodule

/* hdl/scfr_front.sv */
// ----------------------------------------------------------------------------
// scfr_front
// Byte parser: header, task, length, payload and checksum; emits one event
// per checksum byte.
// ----------------------------------------------------------------------------
module scfr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  scfr_pkg::t_byte      i_rx_byte,
    input  scfr_pkg::t_byte      i_len_limit,
    output logic                 o_evt_push,
    output scfr_pkg::t_frame_evt o_evt
);
    import scfr_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HEAD2 = 6'b000010,
        PH_TASK  = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_SUM   = 6'b100000
    } t_phase;

    t_phase               r_phase, n_phase;
    t_byte                r_left, n_left;
    logic [SLOT_IW-1:0]   r_idx, n_idx;
    t_byte                r_sum, n_sum;
    t_byte                r_task, n_task;
    t_byte                r_slot [SLOT_CNT];
    t_byte                n_slot [SLOT_CNT];
    logic                 slot_wr;

    // slot write for a payload or checksum byte while the index is in range
    assign slot_wr = i_accept && (r_idx < SLOT_IW'(SLOT_CNT))
                     && ((r_phase == PH_DATA && r_left != '0) || r_phase == PH_SUM);

    always_comb begin
        for (int i = 0; i < SLOT_CNT; i++) begin
            n_slot[i] = (slot_wr && r_idx == SLOT_IW'(i)) ? i_rx_byte : r_slot[i];
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_task     = r_task;
        o_evt_push = 1'b0;
        if (i_accept) begin
            n_phase = PH_IDLE;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == HEAD1_BYTE) begin
                        n_phase = PH_HEAD2;
                        n_sum   = i_rx_byte;
                    end
                end
                PH_HEAD2: begin
                    if (i_rx_byte == HEAD2_BYTE) begin
                        n_phase = PH_TASK;
                        n_sum   = r_sum + i_rx_byte;
                    end
                end
                PH_TASK: begin
                    if (i_rx_byte < TASK_BAD) begin
                        n_phase = PH_LEN;
                        n_task  = i_rx_byte;
                        n_sum   = r_sum + i_rx_byte;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte < i_len_limit) begin
                        n_phase = PH_DATA;
                        n_left  = i_rx_byte;
                        n_idx   = '0;
                        n_sum   = r_sum + i_rx_byte;
                    end
                end
                PH_DATA: begin
                    // zero length drops straight back to idle
                    if (r_left != '0) begin
                        n_left  = r_left - 1'b1;
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = (r_left == 8'd1) ? PH_SUM : PH_DATA;
                        if (r_idx < SLOT_IW'(SLOT_CNT)) begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
                PH_SUM: begin
                    o_evt_push = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_evt.sum_ok    = (i_rx_byte == r_sum);
        o_evt.task_code = r_task;
        for (int i = 0; i < SLOT_CNT; i++) begin
            o_evt.slots[i*BYTE_W +: BYTE_W] = n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_task  <= '0;
            for (int i = 0; i < SLOT_CNT; i++) begin
                r_slot[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_task  <= n_task;
            for (int i = 0; i < SLOT_CNT; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

endmodule

/* hdl/scfr_evt_fifo.sv */
// ----------------------------------------------------------------------------
// scfr_evt_fifo
// Short queue of frame events between parser and field update.
// ----------------------------------------------------------------------------
module scfr_evt_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  scfr_pkg::t_frame_evt i_evt,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_nonempty,
    output scfr_pkg::t_frame_evt o_evt
);
    import scfr_pkg::*;

    t_frame_evt             r_mem [EVT_DEPTH];
    logic [EVT_PTR_W-1:0]   r_wr, r_rd;
    logic [EVT_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   do_push, do_pop;

    assign o_full     = (r_cnt == EVT_CNT_W'(EVT_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_evt      = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == EVT_PTR_W'(EVT_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == EVT_PTR_W'(EVT_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

endmodule

/* hdl/scfr_back.sv */
// ----------------------------------------------------------------------------
// scfr_back
// Held field and trust counter update; presents one result per event.
// ----------------------------------------------------------------------------
module scfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_evt_valid,
    input  scfr_pkg::t_frame_evt i_evt,
    output logic                 o_evt_pop,
    input  scfr_pkg::t_byte      i_track_task,
    input  logic [scfr_pkg::TRUST_W-1:0] i_trust_limit,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_frame_ok,
    output scfr_pkg::t_byte      o_task_code,
    output scfr_pkg::t_byte      o_line_x,
    output scfr_pkg::t_byte      o_line_rho,
    output scfr_pkg::t_byte      o_cross_mark,
    output scfr_pkg::t_byte      o_detect_flag,
    output scfr_pkg::t_byte      o_frame_rate,
    output scfr_pkg::t_byte      o_ctrl_enable,
    output logic [scfr_pkg::TRUST_W-1:0] o_trust_count,
    output logic                 o_trusted
);
    import scfr_pkg::*;

    logic               r_valid;
    logic               r_ok;
    t_byte              r_task, r_x, r_rho, r_cross, r_flag, r_fps, r_en;
    logic [TRUST_W-1:0] r_cnt;
    logic               r_trust;
    t_byte              s [SLOT_CNT];
    logic               track;

    // held fields only move on a pop, so they double as the output register
    assign o_evt_pop = i_evt_valid && (!r_valid || i_res_ready);
    assign track     = (i_evt.task_code == i_track_task);

    always_comb begin
        for (int i = 0; i < SLOT_CNT; i++) begin
            s[i] = i_evt.slots[i*BYTE_W +: BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
            r_task  <= '0;
            r_x     <= '0;
            r_rho   <= '0;
            r_cross <= '0;
            r_flag  <= '0;
            r_fps   <= '0;
            r_en    <= '0;
            r_cnt   <= '0;
            r_trust <= 1'b0;
        end else begin
            if (o_evt_pop) begin
                r_valid <= 1'b1;
                r_ok    <= i_evt.sum_ok;
                if (i_evt.sum_ok) begin
                    r_task <= i_evt.task_code;
                    if (track) begin
                        r_x     <= s[0];
                        r_rho   <= s[1];
                        r_cross <= s[2];
                        r_flag  <= s[3];
                        r_fps   <= s[4];
                        r_en    <= s[3];
                        priority if (s[3] == '0) begin
                            r_cnt   <= r_cnt >> 1;
                            r_trust <= 1'b0;
                        end else if (r_cnt < i_trust_limit) begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_trust <= 1'b0;
                        end else begin
                            r_trust <= 1'b1;
                        end
                    end else begin
                        r_x   <= '0;
                        r_rho <= '0;
                        r_en  <= '0;
                    end
                end
            end else if (i_res_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_valid;
    assign o_frame_ok    = r_ok;
    assign o_task_code   = r_task;
    assign o_line_x      = r_x;
    assign o_line_rho    = r_rho;
    assign o_cross_mark  = r_cross;
    assign o_detect_flag = r_flag;
    assign o_frame_rate  = r_fps;
    assign o_ctrl_enable = r_en;
    assign o_trust_count = r_cnt;
    assign o_trusted     = r_trust;

endmodule

/* bench/tb_sum_checked_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// tb_sum_checked_frame_receiver_core
// Self-checking bench for the checksummed serial frame receiver. Bytes are
// streamed in bursts, the parser and field update are predicted per accepted
// item, and every result is compared field by field against the prediction.
// ----------------------------------------------------------------------------
module tb_sum_checked_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import scfr_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int WD_LIMIT    = 3000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HEAD2 = 6'b000010,
        PH_TASK  = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_SUM   = 6'b100000
    } t_parse_phase;

    typedef struct {
        logic                frame_ok;
        t_byte               task_code;
        t_byte               line_x;
        t_byte               line_rho;
        t_byte               cross_mark;
        t_byte               detect_flag;
        t_byte               frame_rate;
        t_byte               ctrl_enable;
        logic [TRUST_W-1:0]  trust_count;
        logic                trusted;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    t_byte                i_cfg_data = '0;
    logic                 i_rx_valid = 1'b0;
    logic                 o_rx_ready;
    t_byte                i_rx_byte = '0;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic                 o_frame_ok;
    t_byte                o_task_code;
    t_byte                o_line_x;
    t_byte                o_line_rho;
    t_byte                o_cross_mark;
    t_byte                o_detect_flag;
    t_byte                o_frame_rate;
    t_byte                o_ctrl_enable;
    logic [TRUST_W-1:0]   o_trust_count;
    logic                 o_trusted;

    sum_checked_frame_receiver_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_frame_ok    (o_frame_ok),
        .o_task_code   (o_task_code),
        .o_line_x      (o_line_x),
        .o_line_rho    (o_line_rho),
        .o_cross_mark  (o_cross_mark),
        .o_detect_flag (o_detect_flag),
        .o_frame_rate  (o_frame_rate),
        .o_ctrl_enable (o_ctrl_enable),
        .o_trust_count (o_trust_count),
        .o_trusted     (o_trusted)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register copies
    t_byte              trk_code    = RST_TRACK_TASK;
    t_byte              len_limit   = RST_LEN_LIMIT;
    logic [TRUST_W-1:0] trust_limit = RST_TRUST_LIMIT;

    // parser and held-field copies, reset state
    t_parse_phase       rx_phase   = PH_IDLE;
    t_byte              bytes_left = '0;
    t_byte              pay_idx    = '0;
    t_byte              run_sum    = '0;
    t_byte              task_pend  = '0;
    t_byte              slots [SLOT_CNT] = '{default: '0};
    t_byte              held_task  = '0;
    t_byte              held_x     = '0;
    t_byte              held_rho   = '0;
    t_byte              held_cross = '0;
    t_byte              held_flag  = '0;
    t_byte              held_fps   = '0;
    t_byte              held_en    = '0;
    logic [TRUST_W-1:0] trust_cnt  = '0;
    logic               trust_bit  = 1'b0;

    t_byte         tx_bytes [$];
    t_frame_result expected_frames [$];

    int err_count    = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    logic [15:0] stall_tick = '0;

    t_byte intro_seq [30] = '{
        8'hFF, 8'hFC, 8'h01, 8'h05, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'h00,
        8'hFF, 8'hFF, 8'hFC,
        8'hFF, 8'hFC, 8'hFE, 8'h00, 8'hFF,
        8'hFF, 8'hFC, 8'h02, 8'h01, 8'hAA, 8'hA9,
        8'hFF, 8'hFC, 8'h03, 8'h01, 8'h55, 8'h54
    };

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_count < 40)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // advance the parser by one byte; queue the frame result on a checksum byte
    task automatic parse_rx_byte(input t_byte b);
        t_frame_result r;
        if (rx_phase == PH_IDLE && b == HEAD1_BYTE) begin
            rx_phase = PH_HEAD2;
            run_sum  = b;
        end else if (rx_phase == PH_HEAD2 && b == HEAD2_BYTE) begin
            rx_phase = PH_TASK;
            run_sum  = run_sum + b;
        end else if (rx_phase == PH_TASK && b != TASK_BAD) begin
            rx_phase  = PH_LEN;
            task_pend = b;
            run_sum   = run_sum + b;
        end else if (rx_phase == PH_LEN && b < len_limit) begin
            rx_phase   = PH_DATA;
            bytes_left = b;
            pay_idx    = '0;
            run_sum    = run_sum + b;
        end else if (rx_phase == PH_DATA && bytes_left != 0) begin
            bytes_left = bytes_left - 8'd1;
            if (pay_idx < SLOT_CNT) slots[pay_idx[SLOT_IW-1:0]] = b;
            pay_idx = pay_idx + 8'd1;
            run_sum = run_sum + b;
            if (bytes_left == 0) rx_phase = PH_SUM;
        end else if (rx_phase == PH_SUM) begin
            rx_phase = PH_IDLE;
            // a checksum byte after a payload shorter than the slots lands in a slot
            if (pay_idx < SLOT_CNT) slots[pay_idx[SLOT_IW-1:0]] = b;
            r.frame_ok = (b == run_sum);
            if (r.frame_ok) begin
                held_task = task_pend;
                if (held_task == trk_code) begin
                    held_x     = slots[0];
                    held_rho   = slots[1];
                    held_cross = slots[2];
                    held_flag  = slots[3];
                    held_fps   = slots[4];
                    held_en    = slots[3];
                    if (slots[3] != 0) begin
                        if (trust_cnt < trust_limit) begin
                            trust_cnt = trust_cnt + 1'b1;
                            trust_bit = 1'b0;
                        end else begin
                            trust_bit = 1'b1;
                        end
                    end else begin
                        trust_cnt = trust_cnt >> 1;
                        trust_bit = 1'b0;
                    end
                end else begin
                    held_x   = '0;
                    held_rho = '0;
                    held_en  = '0;
                end
            end
            r.task_code   = held_task;
            r.line_x      = held_x;
            r.line_rho    = held_rho;
            r.cross_mark  = held_cross;
            r.detect_flag = held_flag;
            r.frame_rate  = held_fps;
            r.ctrl_enable = held_en;
            r.trust_count = trust_cnt;
            r.trusted     = trust_bit;
            expected_frames.push_back(r);
        end else begin
            rx_phase = PH_IDLE;
        end
    endtask

    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            i_rx_byte  <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (i_rx_valid && o_rx_ready) parse_rx_byte(i_rx_byte);
            if (!i_rx_valid || o_rx_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_rx_valid <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= tx_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(48, 1);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_frame_result want;
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            hold_left   <= 0;
            hold_ack    <= 0;
            stall_tick  <= '0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result with nothing expected", 8'd1, 8'd0);
                end else begin
                    want = expected_frames.pop_front();
                    if (o_frame_ok !== want.frame_ok)
                        report_mismatch("frame_ok", 8'(o_frame_ok), 8'(want.frame_ok));
                    if (o_task_code !== want.task_code)
                        report_mismatch("task_code", o_task_code, want.task_code);
                    if (o_line_x !== want.line_x)
                        report_mismatch("line_x", o_line_x, want.line_x);
                    if (o_line_rho !== want.line_rho)
                        report_mismatch("line_rho", o_line_rho, want.line_rho);
                    if (o_cross_mark !== want.cross_mark)
                        report_mismatch("cross_mark", o_cross_mark, want.cross_mark);
                    if (o_detect_flag !== want.detect_flag)
                        report_mismatch("detect_flag", o_detect_flag, want.detect_flag);
                    if (o_frame_rate !== want.frame_rate)
                        report_mismatch("frame_rate", o_frame_rate, want.frame_rate);
                    if (o_ctrl_enable !== want.ctrl_enable)
                        report_mismatch("ctrl_enable", o_ctrl_enable, want.ctrl_enable);
                    if (o_trust_count !== want.trust_count)
                        report_mismatch("trust_count", 8'(o_trust_count),
                                        8'(want.trust_count));
                    if (o_trusted !== want.trusted)
                        report_mismatch("trusted", 8'(o_trusted), 8'(want.trusted));
                end
            end
            stall_tick <= stall_tick + 16'd1;
            if (hold_ack != hold_req) begin
                // long hold-off so the event queue fills and the input stalls
                hold_ack    <= hold_req;
                hold_left   <= HOLD_CYCLES;
                i_res_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_res_ready <= 1'b0;
            end else begin
                case (stall_tick[10:9])
                    2'd0:    i_res_ready <= 1'b1;
                    2'd1:    i_res_ready <= (stall_tick[2:0] < 3'd5);
                    2'd2:    i_res_ready <= 1'($urandom_range(1));
                    default: i_res_ready <= (stall_tick[1:0] != 2'b11);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WD_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
            $display("[sum_checked_frame_receiver_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_byte val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TRACK_TASK:  trk_code    = val;
            CFG_LEN_LIMIT:   len_limit   = val;
            CFG_TRUST_LIMIT: trust_limit = val[TRUST_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every item is sent and every result is back, then settle
    task automatic drain();
        do @(negedge i_clk);
        while (tx_bytes.size() != 0 || i_rx_valid || expected_frames.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_byte random_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return HEAD1_BYTE;
            2:       return HEAD2_BYTE;
            default: return t_byte'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input t_byte code, input int len, input int zero_pct,
                               input bit bad_sum);
        t_byte sum;
        t_byte b;
        tx_bytes.push_back(HEAD1_BYTE);
        tx_bytes.push_back(HEAD2_BYTE);
        tx_bytes.push_back(code);
        tx_bytes.push_back(t_byte'(len));
        sum = HEAD1_BYTE + HEAD2_BYTE + code + t_byte'(len);
        for (int i = 0; i < len; i++) begin
            b = random_byte();
            if (i == 3) begin
                if ($urandom_range(99) < zero_pct) b = 8'h00;
                else if (b == 8'h00) b = 8'h01;
            end
            tx_bytes.push_back(b);
            sum = sum + b;
        end
        if (bad_sum) sum = sum + t_byte'($urandom_range(255, 1));
        tx_bytes.push_back(sum);
    endtask

    // mostly well-formed frames with random content, the rest noise and aborts
    task automatic queue_random_traffic(input int n_bytes, input int zero_pct,
                                        input int track_pct);
        int    added;
        int    start_size;
        int    sel;
        int    len;
        int    short_max;
        t_byte code;
        t_byte b;
        added = 0;
        while (added < n_bytes) begin
            start_size = tx_bytes.size();
            code = ($urandom_range(99) < track_pct) ? trk_code : t_byte'($urandom_range(254));
            sel  = $urandom_range(99);
            if (sel < 80) begin
                short_max = (len_limit > 8) ? 8 : int'(len_limit) - 1;
                sel = $urandom_range(99);
                if (len_limit == 1 || sel < 5) len = 0;
                else if (sel < 8) len = $urandom_range(int'(len_limit) - 1, 1);
                else len = $urandom_range(short_max, 1);
                queue_frame(code, len, zero_pct, $urandom_range(99) < 10);
            end else if (sel < 90) begin
                repeat ($urandom_range(6, 1)) tx_bytes.push_back(random_byte());
            end else begin
                tx_bytes.push_back(HEAD1_BYTE);
                case ($urandom_range(3))
                    0: begin
                        b = random_byte();
                        if (b == HEAD2_BYTE) b = 8'h00;
                        tx_bytes.push_back(b);
                    end
                    1: begin
                        tx_bytes.push_back(HEAD2_BYTE);
                        tx_bytes.push_back(TASK_BAD);
                    end
                    2: begin
                        tx_bytes.push_back(HEAD2_BYTE);
                        tx_bytes.push_back(code);
                        tx_bytes.push_back(t_byte'($urandom_range(255, int'(len_limit))));
                    end
                    default: begin
                        tx_bytes.push_back(HEAD2_BYTE);
                        tx_bytes.push_back(code);
                        tx_bytes.push_back(8'h00);
                    end
                endcase
            end
            added += tx_bytes.size() - start_size;
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames at reset settings
        foreach (intro_seq[i]) tx_bytes.push_back(intro_seq[i]);
        drain();

        write_reg(CFG_TRACK_TASK, 8'd0);
        write_reg(CFG_LEN_LIMIT, 8'd255);
        write_reg(CFG_TRUST_LIMIT, 8'd0);
        @(negedge i_clk);
        queue_random_traffic(250, 20, 60);
        drain();

        write_reg(CFG_TRACK_TASK, 8'd254);
        write_reg(CFG_LEN_LIMIT, 8'd1);
        write_reg(CFG_TRUST_LIMIT, 8'd63);
        @(negedge i_clk);
        queue_random_traffic(60, 20, 60);
        drain();

        write_reg(CFG_TRACK_TASK, RST_TRACK_TASK);
        write_reg(CFG_LEN_LIMIT, 8'd12);
        write_reg(CFG_TRUST_LIMIT, 8'd3);
        @(negedge i_clk);
        hold_req = hold_req + 1;
        queue_random_traffic(300, 30, 60);
        drain();

        // long run of detections to walk the counter up to its top
        write_reg(CFG_TRACK_TASK, 8'd7);
        write_reg(CFG_LEN_LIMIT, 8'd6);
        write_reg(CFG_TRUST_LIMIT, 8'd63);
        @(negedge i_clk);
        queue_random_traffic(800, 0, 95);
        drain();

        repeat (2) begin
            write_reg(CFG_TRACK_TASK, t_byte'($urandom_range(254)));
            write_reg(CFG_LEN_LIMIT, t_byte'($urandom_range(255, 1)));
            write_reg(CFG_TRUST_LIMIT, t_byte'($urandom_range(63)));
            @(negedge i_clk);
            queue_random_traffic(120, $urandom_range(50), 70);
            drain();
        end

        if (err_count == 0)
            $display("[sum_checked_frame_receiver_core] OK");
        else
            $display("[sum_checked_frame_receiver_core] ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/scfr_pkg.sv
hdl/scfr_front.sv
hdl/scfr_evt_fifo.sv
hdl/scfr_back.sv
hdl/sum_checked_frame_receiver_core.sv
bench/tb_sum_checked_frame_receiver_core.sv
